// ----- rtl/arprr_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ARP resolver/responder package
// Shared types, codes and protocol constants for the resolver and its engine.
// ----------------------------------------------------------------------------
package arprr_pkg;

    localparam logic [15:0] HTYPE_ETHERNET = 16'h0001;
    localparam logic [15:0] PTYPE_IPV4     = 16'h0800;
    localparam logic [7:0]  HLEN_ETHERNET  = 8'd6;
    localparam logic [7:0]  PLEN_IPV4      = 8'd4;
    localparam logic [15:0] OPER_REQUEST   = 16'h0001;
    localparam logic [15:0] OPER_REPLY     = 16'h0002;

    localparam logic [15:0] TIMEOUT_RESET  = 16'd2000;
    localparam logic [3:0]  RETRIES_RESET  = 4'd4;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 48;
    localparam logic [CFG_IDX_W-1:0] CFG_OWN_IP        = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OWN_MAC       = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_TICKS = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RETRY_LIMIT   = 2'd3;

    localparam int IN_DATA_W  = 208;
    localparam int OUT_DATA_W = 160;

    typedef enum logic [1:0] {
        CMD_RESOLVE = 2'd0,
        CMD_PACKET  = 2'd1,
        CMD_TICK    = 2'd2
    } t_cmd;

    typedef enum logic [2:0] {
        KIND_REQUEST  = 3'd0,
        KIND_REPLY    = 3'd1,
        KIND_RESOLVED = 3'd2,
        KIND_TIMEOUT  = 3'd3,
        KIND_BUSY     = 3'd4
    } t_kind;

    typedef struct packed {
        t_cmd        command;
        logic [31:0] resolve_ip;
        logic [15:0] pkt_htype;
        logic [15:0] pkt_ptype;
        logic [7:0]  pkt_hlen;
        logic [7:0]  pkt_plen;
        logic [15:0] pkt_oper;
        logic [47:0] pkt_sender_mac;
        logic [31:0] pkt_sender_ip;
        logic [31:0] pkt_target_ip;
    } t_item;

    typedef struct packed {
        logic [31:0] own_ip;
        logic [15:0] timeout_ticks;
        logic [3:0]  retry_limit;
    } t_cfg;

    typedef struct packed {
        logic        valid;
        t_kind       kind;
        logic [47:0] out_target_mac;
        logic [31:0] out_sender_ip;
        logic [31:0] out_target_ip;
        logic [47:0] resolved_mac;
    } t_result;

endpackage

// ----- rtl/arprr_engine.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ARP resolver engine
// Holds the pending resolve and its retry timer, and decides the result of
// one registered item combinationally.
// ----------------------------------------------------------------------------
module arprr_engine (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  arprr_pkg::t_item  i_item,
    input  arprr_pkg::t_cfg   i_cfg,
    output arprr_pkg::t_result o_res
);

    logic        r_pending;
    logic [31:0] r_pending_ip;
    logic [3:0]  r_retries_left;
    logic [15:0] r_ticks_left;

    logic        n_pending;
    logic [31:0] n_pending_ip;
    logic [3:0]  n_retries_left;
    logic [15:0] n_ticks_left;

    logic        hdr_ok;

    assign hdr_ok = (i_item.pkt_htype == arprr_pkg::HTYPE_ETHERNET)
                 && (i_item.pkt_ptype == arprr_pkg::PTYPE_IPV4)
                 && (i_item.pkt_hlen  == arprr_pkg::HLEN_ETHERNET)
                 && (i_item.pkt_plen  == arprr_pkg::PLEN_IPV4);

    always_comb begin
        n_pending      = r_pending;
        n_pending_ip   = r_pending_ip;
        n_retries_left = r_retries_left;
        n_ticks_left   = r_ticks_left;
        o_res          = '0;
        o_res.kind     = arprr_pkg::KIND_REQUEST;

        case (i_item.command)
            arprr_pkg::CMD_RESOLVE: begin
                if (r_pending) begin
                    o_res.valid = 1'b1;
                    o_res.kind  = arprr_pkg::KIND_BUSY;
                end else begin
                    n_pending           = 1'b1;
                    n_pending_ip        = i_item.resolve_ip;
                    n_retries_left      = i_cfg.retry_limit;
                    n_ticks_left        = i_cfg.timeout_ticks;
                    o_res.valid         = 1'b1;
                    o_res.kind          = arprr_pkg::KIND_REQUEST;
                    o_res.out_sender_ip = i_cfg.own_ip;
                    o_res.out_target_ip = i_item.resolve_ip;
                end
            end
            arprr_pkg::CMD_PACKET: begin
                if (hdr_ok && i_item.pkt_oper == arprr_pkg::OPER_REPLY) begin
                    if (r_pending && i_item.pkt_sender_ip == r_pending_ip) begin
                        n_pending          = 1'b0;
                        n_ticks_left       = '0;
                        o_res.valid        = 1'b1;
                        o_res.kind         = arprr_pkg::KIND_RESOLVED;
                        o_res.resolved_mac = i_item.pkt_sender_mac;
                    end
                end else if (hdr_ok && i_item.pkt_oper == arprr_pkg::OPER_REQUEST
                             && i_item.pkt_target_ip == i_cfg.own_ip) begin
                    // A reply leaves the request timer alone.
                    o_res.valid          = 1'b1;
                    o_res.kind           = arprr_pkg::KIND_REPLY;
                    o_res.out_target_mac = i_item.pkt_sender_mac;
                    o_res.out_sender_ip  = i_item.pkt_target_ip;
                    o_res.out_target_ip  = i_item.pkt_sender_ip;
                end
            end
            arprr_pkg::CMD_TICK: begin
                if (r_pending) begin
                    if (r_ticks_left > 16'd1) begin
                        n_ticks_left = r_ticks_left - 16'd1;
                    end else if (r_retries_left != 4'd0) begin
                        n_retries_left      = r_retries_left - 4'd1;
                        n_ticks_left        = i_cfg.timeout_ticks;
                        o_res.valid         = 1'b1;
                        o_res.kind          = arprr_pkg::KIND_REQUEST;
                        o_res.out_sender_ip = i_cfg.own_ip;
                        o_res.out_target_ip = r_pending_ip;
                    end else begin
                        n_pending          = 1'b0;
                        n_ticks_left       = '0;
                        o_res.valid        = 1'b1;
                        o_res.kind         = arprr_pkg::KIND_TIMEOUT;
                        o_res.resolved_mac = '1;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending      <= 1'b0;
            r_pending_ip   <= '0;
            r_retries_left <= '0;
            r_ticks_left   <= '0;
        end else if (i_en) begin
            r_pending      <= n_pending;
            r_pending_ip   <= n_pending_ip;
            r_retries_left <= n_retries_left;
            r_ticks_left   <= n_ticks_left;
        end
    end

    // A completed or failed resolve always clears the pending flag.
    a_done_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_en && o_res.valid && (o_res.kind == arprr_pkg::KIND_RESOLVED
                                 || o_res.kind == arprr_pkg::KIND_TIMEOUT))
        |=> !r_pending)
        else $error("pending not cleared after resolve finished");

    // A resolve only starts together with a request send.
    a_start_sends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_pending) |-> $past(i_en && o_res.valid
                                   && o_res.kind == arprr_pkg::KIND_REQUEST))
        else $error("pending set without a request send");

    // Timeout is given only once the retries are used up.
    a_timeout_no_retries: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_en && o_res.valid && o_res.kind == arprr_pkg::KIND_TIMEOUT)
        |-> (r_retries_left == 4'd0))
        else $error("timeout with retries left");

    // Busy is only reported while a resolve is pending, and it stays pending.
    a_busy_keeps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_en && o_res.valid && o_res.kind == arprr_pkg::KIND_BUSY)
        |=> r_pending && $stable(r_pending_ip))
        else $error("busy result disturbed the pending resolve");

endmodule

// ----- rtl/arp_resolver_responder.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ARP resolver and responder
// Resolves one IPv4 address at a time and answers ARP requests for own_ip.
// ----------------------------------------------------------------------------
// The block takes one beat per clock cycle while its result register can
// drain, and gives at most one result beat for each. A beat is held in the
// input register, is decided by a single pass of compares, and its result
// is presented from the result register. Command 0 on tuser starts a
// resolve, command 1 carries a parsed ARP header, command 2 is a timer tick.
// Input beats keep flowing while a result waits, as long as the result
// register can drain; while it is stalled, one more beat can still be held.
// ----------------------------------------------------------------------------
module arp_resolver_responder (
    input  logic                            i_clk,
    input  logic                            i_rst_n,

    input  logic                            i_cfg_we,
    input  logic [arprr_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [arprr_pkg::CFG_DATA_W-1:0] i_cfg_data,

    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // resolve_ip, pkt_htype, pkt_ptype, pkt_hlen, pkt_plen, pkt_oper,
    // pkt_sender_mac, pkt_sender_ip, pkt_target_ip
    input  logic [arprr_pkg::IN_DATA_W-1:0] s_axis_tdata,
    // command
    input  logic [1:0]                      s_axis_tuser,

    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // out_target_mac, out_sender_ip, out_target_ip, resolved_mac
    output logic [arprr_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    // kind
    output logic [2:0]                      m_axis_tuser
);

    logic [31:0]        r_own_ip;
    logic [15:0]        r_timeout_ticks;
    logic [3:0]         r_retry_limit;

    logic               r_in_valid;
    arprr_pkg::t_item   r_in;
    logic               r_out_valid;
    arprr_pkg::t_result r_out;

    arprr_pkg::t_cfg    cfg;
    arprr_pkg::t_result res;
    logic               out_free;
    logic               consume;

    // own_mac is written but is not read anywhere in this block.
    logic [47:0]        r_own_mac;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_ip        <= '0;
            r_own_mac       <= '0;
            r_timeout_ticks <= arprr_pkg::TIMEOUT_RESET;
            r_retry_limit   <= arprr_pkg::RETRIES_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                arprr_pkg::CFG_OWN_IP:        r_own_ip        <= i_cfg_data[31:0];
                arprr_pkg::CFG_OWN_MAC:       r_own_mac       <= i_cfg_data;
                arprr_pkg::CFG_TIMEOUT_TICKS: r_timeout_ticks <= i_cfg_data[15:0];
                arprr_pkg::CFG_RETRY_LIMIT:   r_retry_limit   <= i_cfg_data[3:0];
                default: begin
                end
            endcase
        end
    end

    assign cfg.own_ip        = r_own_ip;
    assign cfg.timeout_ticks = r_timeout_ticks;
    assign cfg.retry_limit   = r_retry_limit;

    assign out_free      = !r_out_valid || m_axis_tready;
    assign consume       = r_in_valid && out_free;
    assign s_axis_tready = !r_in_valid || out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in.command        <= arprr_pkg::t_cmd'(s_axis_tuser);
            r_in.resolve_ip     <= s_axis_tdata[31:0];
            r_in.pkt_htype      <= s_axis_tdata[47:32];
            r_in.pkt_ptype      <= s_axis_tdata[63:48];
            r_in.pkt_hlen       <= s_axis_tdata[71:64];
            r_in.pkt_plen       <= s_axis_tdata[79:72];
            r_in.pkt_oper       <= s_axis_tdata[95:80];
            r_in.pkt_sender_mac <= s_axis_tdata[143:96];
            r_in.pkt_sender_ip  <= s_axis_tdata[175:144];
            r_in.pkt_target_ip  <= s_axis_tdata[207:176];
        end
    end

    arprr_engine u_engine (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (consume),
        .i_item  (r_in),
        .i_cfg   (cfg),
        .o_res   (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= consume && res.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (consume && res.valid) begin
            r_out <= res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out.kind;
    assign m_axis_tdata  = {r_out.resolved_mac, r_out.out_target_ip,
                            r_out.out_sender_ip, r_out.out_target_mac};

endmodule

// ----- sim/arp_resolver_responder_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ARP resolver/responder testbench
// Sends resolve commands, parsed ARP headers and timer ticks over the input
// stream and checks every result beat against a cycle-free predictor of the
// resolver. A short directed sweep comes first, then six random phases, each
// with its own register setting. Both stream sides idle and stall at random.
// ----------------------------------------------------------------------------
module arp_resolver_responder_tb;

    localparam int PER_PHASE   = 235;
    localparam int N_PHASES    = 6;
    localparam int SETTLE      = 8;
    localparam int HOLD_CYCLES = 300;
    localparam int LIMIT       = 400000;

    localparam logic [15:0] HT_ETH = arprr_pkg::HTYPE_ETHERNET;
    localparam logic [15:0] PT_IP4 = arprr_pkg::PTYPE_IPV4;
    localparam logic [7:0]  HL_ETH = arprr_pkg::HLEN_ETHERNET;
    localparam logic [7:0]  PL_IP4 = arprr_pkg::PLEN_IPV4;
    localparam logic [15:0] OP_REQ = arprr_pkg::OPER_REQUEST;
    localparam logic [15:0] OP_REP = arprr_pkg::OPER_REPLY;

    typedef struct packed {
        arprr_pkg::t_kind kind;
        logic [47:0]      tmac;
        logic [31:0]      sip;
        logic [31:0]      tip;
        logic [47:0]      rmac;
    } t_arp_beat;

    typedef struct packed {
        bit               typed;
        bit               has_res;
        arprr_pkg::t_item item;
        t_arp_beat        res;
    } t_dir_row;

    logic                              i_clk;
    logic                              i_rst_n;
    logic                              i_cfg_we;
    logic [arprr_pkg::CFG_IDX_W-1:0]   i_cfg_idx;
    logic [arprr_pkg::CFG_DATA_W-1:0]  i_cfg_data;
    logic                              s_axis_tvalid;
    logic                              s_axis_tready;
    logic [arprr_pkg::IN_DATA_W-1:0]   s_axis_tdata;
    logic [1:0]                        s_axis_tuser;
    logic                              m_axis_tvalid;
    logic                              m_axis_tready;
    logic [arprr_pkg::OUT_DATA_W-1:0]  m_axis_tdata;
    logic [2:0]                        m_axis_tuser;

    // Predictor copy of the resolver state and registers.
    logic        rs_pending;
    logic [31:0] rs_ip;
    logic [3:0]  rs_retries;
    logic [15:0] rs_ticks;
    logic [31:0] cf_own_ip;
    logic [47:0] cf_own_mac;
    logic [15:0] cf_timeout;
    logic [3:0]  cf_retries;

    t_arp_beat arp_due_q[$];
    t_dir_row  dir_rows[$];
    t_arp_beat want;

    int  n_err;
    int  kind_seen[5];
    int  n_directed;
    int  n_random;
    int  burst_left;
    int  hold_cnt;
    int  rx_cyc;
    int  wd_cyc;
    bit  hold_req;

    arp_resolver_responder uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic logic [47:0] rand48();
        return {16'($urandom), 32'($urandom)};
    endfunction

    function automatic arprr_pkg::t_item arp_cmd(input arprr_pkg::t_cmd c,
                                                 input logic [31:0] ip);
        arprr_pkg::t_item x;
        x = '0;
        x.command = c;
        x.resolve_ip = ip;
        return x;
    endfunction

    function automatic arprr_pkg::t_item arp_pkt(input logic [15:0] ht,
                                                 input logic [15:0] pt,
                                                 input logic [7:0] hl, input logic [7:0] pl,
                                                 input logic [15:0] op,
                                                 input logic [47:0] smac,
                                                 input logic [31:0] sip,
                                                 input logic [31:0] tip);
        arprr_pkg::t_item x;
        x = '0;
        x.command = arprr_pkg::CMD_PACKET;
        x.pkt_htype = ht;
        x.pkt_ptype = pt;
        x.pkt_hlen = hl;
        x.pkt_plen = pl;
        x.pkt_oper = op;
        x.pkt_sender_mac = smac;
        x.pkt_sender_ip = sip;
        x.pkt_target_ip = tip;
        return x;
    endfunction

    function automatic t_arp_beat make_beat(input arprr_pkg::t_kind k,
                                            input logic [47:0] tmac,
                                            input logic [31:0] sip, input logic [31:0] tip,
                                            input logic [47:0] rmac);
        t_arp_beat b;
        b.kind = k;
        b.tmac = tmac;
        b.sip = sip;
        b.tip = tip;
        b.rmac = rmac;
        return b;
    endfunction

    // Works out the result of one accepted beat and advances the predictor state.
    function automatic bit arp_decide(input arprr_pkg::t_item x, output t_arp_beat b);
        b = '0;
        case (x.command)
            arprr_pkg::CMD_RESOLVE: begin
                if (rs_pending) begin
                    b.kind = arprr_pkg::KIND_BUSY;
                    return 1'b1;
                end
                rs_pending = 1'b1;
                rs_ip = x.resolve_ip;
                rs_retries = cf_retries;
                rs_ticks = cf_timeout;
                b.kind = arprr_pkg::KIND_REQUEST;
                b.sip = cf_own_ip;
                b.tip = rs_ip;
                return 1'b1;
            end
            arprr_pkg::CMD_PACKET: begin
                if (x.pkt_htype != HT_ETH || x.pkt_ptype != PT_IP4 ||
                    x.pkt_hlen != HL_ETH || x.pkt_plen != PL_IP4)
                    return 1'b0;
                if (x.pkt_oper == OP_REP) begin
                    if (!rs_pending || x.pkt_sender_ip != rs_ip)
                        return 1'b0;
                    rs_pending = 1'b0;
                    rs_ticks = '0;
                    b.kind = arprr_pkg::KIND_RESOLVED;
                    b.rmac = x.pkt_sender_mac;
                    return 1'b1;
                end
                // Answering a request leaves the request timer alone.
                if (x.pkt_oper == OP_REQ && x.pkt_target_ip == cf_own_ip) begin
                    b.kind = arprr_pkg::KIND_REPLY;
                    b.tmac = x.pkt_sender_mac;
                    b.sip = x.pkt_target_ip;
                    b.tip = x.pkt_sender_ip;
                    return 1'b1;
                end
                return 1'b0;
            end
            arprr_pkg::CMD_TICK: begin
                if (!rs_pending)
                    return 1'b0;
                if (rs_ticks > 16'd1) begin
                    rs_ticks = rs_ticks - 16'd1;
                    return 1'b0;
                end
                if (rs_retries != '0) begin
                    rs_retries = rs_retries - 4'd1;
                    rs_ticks = cf_timeout;
                    b.kind = arprr_pkg::KIND_REQUEST;
                    b.sip = cf_own_ip;
                    b.tip = rs_ip;
                    return 1'b1;
                end
                rs_pending = 1'b0;
                rs_ticks = '0;
                b.kind = arprr_pkg::KIND_TIMEOUT;
                b.rmac = '1;
                return 1'b1;
            end
            default: return 1'b0;
        endcase
    endfunction

    // Mostly well-formed traffic that follows the pending resolve, with some
    // broken headers and raw noise mixed in. Neither counts as useful.
    function automatic arprr_pkg::t_item gen_item(output bit useful);
        arprr_pkg::t_item x;
        int               sel;
        x.command = arprr_pkg::t_cmd'(2'($urandom_range(0, 3)));
        x.resolve_ip = 32'($urandom);
        x.pkt_htype = 16'($urandom);
        x.pkt_ptype = 16'($urandom);
        x.pkt_hlen = 8'($urandom);
        x.pkt_plen = 8'($urandom);
        x.pkt_oper = 16'($urandom);
        x.pkt_sender_mac = rand48();
        x.pkt_sender_ip = 32'($urandom);
        x.pkt_target_ip = 32'($urandom);
        useful = 1'b1;
        sel = $urandom_range(0, 99);
        if (sel < 48 || sel >= 93) begin
            x.command = arprr_pkg::CMD_PACKET;
            x.pkt_htype = HT_ETH;
            x.pkt_ptype = PT_IP4;
            x.pkt_hlen = HL_ETH;
            x.pkt_plen = PL_IP4;
        end
        if (sel < 14) begin
            x.command = arprr_pkg::CMD_RESOLVE;
        end else if (sel < 34) begin
            x.pkt_oper = OP_REP;
            if (rs_pending && $urandom_range(0, 9) != 0)
                x.pkt_sender_ip = rs_ip;
        end else if (sel < 48) begin
            x.pkt_oper = OP_REQ;
            if ($urandom_range(0, 4) != 0)
                x.pkt_target_ip = cf_own_ip;
        end else if (sel < 86) begin
            x.command = arprr_pkg::CMD_TICK;
        end else begin
            useful = 1'b0;
            if (sel >= 93) begin
                // A near miss: good traffic with exactly one header field wrong.
                x.pkt_oper = $urandom_range(0, 1) ? OP_REP : OP_REQ;
                x.pkt_sender_ip = rs_ip;
                x.pkt_target_ip = cf_own_ip;
                case ($urandom_range(0, 3))
                    0: x.pkt_htype = HT_ETH ^ 16'($urandom_range(1, 65535));
                    1: x.pkt_ptype = PT_IP4 ^ 16'($urandom_range(1, 65535));
                    2: x.pkt_hlen = HL_ETH ^ 8'($urandom_range(1, 255));
                    default: x.pkt_plen = PL_IP4 ^ 8'($urandom_range(1, 255));
                endcase
            end
        end
        return x;
    endfunction

    // Bursts of back-to-back beats with idle gaps between them; no gaps while
    // the receiver holds off, so that the block fills up.
    function automatic int next_gap();
        if (hold_req || hold_cnt != 0)
            return 0;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            return ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end
        burst_left--;
        return 0;
    endfunction

    task automatic add_row(input arprr_pkg::t_item x, input bit typed, input bit has_res,
                           input t_arp_beat res);
        t_dir_row r;
        r.typed = typed;
        r.has_res = has_res;
        r.item = x;
        r.res = res;
        dir_rows.push_back(r);
    endtask

    // Returns in the time step at which the beat is taken.
    task automatic drive_item(input arprr_pkg::t_item x, input int gap);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= x.command;
        s_axis_tdata <= {x.pkt_target_ip, x.pkt_sender_ip, x.pkt_sender_mac, x.pkt_oper,
                         x.pkt_plen, x.pkt_hlen, x.pkt_ptype, x.pkt_htype, x.resolve_ip};
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (arp_due_q.size() != 0) @(posedge i_clk);
        // Beats that give no result may still be in flight.
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic reg_write(input logic [arprr_pkg::CFG_IDX_W-1:0] idx,
                             input logic [arprr_pkg::CFG_DATA_W-1:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
    endtask

    // Unused upper bits of the IP, timeout and retry writes carry junk, which the block must drop.
    task automatic program_regs(input logic [31:0] ip, input logic [47:0] mac,
                                input logic [15:0] tmo, input logic [3:0] rl);
        logic [47:0] d;
        d = rand48();
        d[31:0] = ip;
        reg_write(arprr_pkg::CFG_OWN_IP, d);
        reg_write(arprr_pkg::CFG_OWN_MAC, mac);
        d = rand48();
        d[15:0] = tmo;
        reg_write(arprr_pkg::CFG_TIMEOUT_TICKS, d);
        d = rand48();
        d[3:0] = rl;
        reg_write(arprr_pkg::CFG_RETRY_LIMIT, d);
        i_cfg_we <= 1'b0;
        cf_own_ip = ip;
        cf_own_mac = mac;
        cf_timeout = tmo;
        cf_retries = rl;
    endtask

    // Receiver: its own stall pattern, plus one long hold-off on request.
    initial begin
        m_axis_tready <= 1'b0;
        rx_cyc = 0;
        hold_cnt = 0;
        forever begin
            @(posedge i_clk);
            rx_cyc++;
            if (hold_req) begin
                hold_req = 1'b0;
                hold_cnt = HOLD_CYCLES;
            end
            if (hold_cnt != 0) begin
                hold_cnt--;
                m_axis_tready <= 1'b0;
            end else begin
                case ((rx_cyc / 97) % 4)
                    0: m_axis_tready <= 1'b1;
                    1: m_axis_tready <= ($urandom_range(0, 3) != 0);
                    2: m_axis_tready <= ($urandom_range(0, 3) == 0);
                    default: m_axis_tready <= rx_cyc[0];
                endcase
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (arp_due_q.size() == 0) begin
                $error("result beat of kind %0d with nothing expected", m_axis_tuser);
                n_err++;
            end else begin
                want = arp_due_q.pop_front();
                kind_seen[int'(want.kind)]++;
                if (m_axis_tuser !== want.kind) begin
                    $error("kind: expected %0d, actual %0d", want.kind, m_axis_tuser);
                    n_err++;
                end
                if (m_axis_tdata[47:0] !== want.tmac) begin
                    $error("out_target_mac: expected %h, actual %h", want.tmac,
                           m_axis_tdata[47:0]);
                    n_err++;
                end
                if (m_axis_tdata[79:48] !== want.sip) begin
                    $error("out_sender_ip: expected %h, actual %h", want.sip,
                           m_axis_tdata[79:48]);
                    n_err++;
                end
                if (m_axis_tdata[111:80] !== want.tip) begin
                    $error("out_target_ip: expected %h, actual %h", want.tip,
                           m_axis_tdata[111:80]);
                    n_err++;
                end
                if (m_axis_tdata[159:112] !== want.rmac) begin
                    $error("resolved_mac: expected %h, actual %h", want.rmac,
                           m_axis_tdata[159:112]);
                    n_err++;
                end
            end
        end
    end

    initial begin
        for (wd_cyc = 0; wd_cyc < LIMIT; wd_cyc++) @(posedge i_clk);
        $display("Timed out after %0d cycles.", LIMIT);
        $display("CHECK FAILED");
        $finish;
    end

    initial begin
        arprr_pkg::t_item x;
        t_arp_beat        b;
        bit               got;
        bit               useful;
        int               count;
        int               p;

        i_rst_n <= 1'b0;
        i_cfg_we <= 1'b0;
        i_cfg_idx <= '0;
        i_cfg_data <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata <= '0;
        s_axis_tuser <= '0;
        n_err = 0;
        n_directed = 0;
        n_random = 0;
        burst_left = 0;
        hold_req = 1'b0;
        for (int k = 0; k < 5; k++) kind_seen[k] = 0;
        rs_pending = 1'b0;
        rs_ip = '0;
        rs_retries = '0;
        rs_ticks = '0;
        cf_own_ip = '0;
        cf_own_mac = '0;
        cf_timeout = arprr_pkg::TIMEOUT_RESET;
        cf_retries = arprr_pkg::RETRIES_RESET;

        // Directed sweep, run on the register values left by reset.
        add_row(arp_cmd(arprr_pkg::CMD_TICK, '1), 1'b1, 1'b0, '0);
        add_row(arp_cmd(arprr_pkg::CMD_RESOLVE, '1), 1'b1, 1'b1,
                make_beat(arprr_pkg::KIND_REQUEST, '0, '0, '1, '0));
        add_row(arp_cmd(arprr_pkg::CMD_RESOLVE, '0), 1'b1, 1'b1,
                make_beat(arprr_pkg::KIND_BUSY, '0, '0, '0, '0));
        add_row(arp_cmd(arprr_pkg::CMD_TICK, '0), 1'b0, 1'b0, '0);
        add_row(arp_pkt('0, PT_IP4, HL_ETH, PL_IP4, OP_REP, '1, '1, '0), 1'b1, 1'b0, '0);
        add_row(arp_pkt(HT_ETH, '1, HL_ETH, PL_IP4, OP_REP, '1, '1, '0), 1'b1, 1'b0, '0);
        add_row(arp_pkt(HT_ETH, PT_IP4, '1, PL_IP4, OP_REP, '1, '1, '0), 1'b1, 1'b0, '0);
        add_row(arp_pkt(HT_ETH, PT_IP4, HL_ETH, '0, OP_REP, '1, '1, '0), 1'b1, 1'b0, '0);
        add_row(arp_pkt(HT_ETH, PT_IP4, HL_ETH, PL_IP4, '0, '1, '1, '0), 1'b1, 1'b0, '0);
        add_row(arp_pkt(HT_ETH, PT_IP4, HL_ETH, PL_IP4, '1, '1, '1, '0), 1'b1, 1'b0, '0);
        add_row(arp_pkt(HT_ETH, PT_IP4, HL_ETH, PL_IP4, OP_REP, '1, '0, '0),
                1'b0, 1'b0, '0);
        add_row(arp_pkt(HT_ETH, PT_IP4, HL_ETH, PL_IP4, OP_REQ, '1, '1, '0), 1'b1, 1'b1,
                make_beat(arprr_pkg::KIND_REPLY, '1, '0, '1, '0));
        add_row(arp_pkt(HT_ETH, PT_IP4, HL_ETH, PL_IP4, OP_REQ, '1, '1, '1),
                1'b0, 1'b0, '0);
        add_row(arp_cmd(arprr_pkg::t_cmd'(2'd3), '1), 1'b1, 1'b0, '0);
        add_row(arp_pkt(HT_ETH, PT_IP4, HL_ETH, PL_IP4, OP_REP, '1, '1, '0), 1'b1, 1'b1,
                make_beat(arprr_pkg::KIND_RESOLVED, '0, '0, '0, '1));
        add_row(arp_pkt(HT_ETH, PT_IP4, HL_ETH, PL_IP4, OP_REP, '1, '1, '0),
                1'b0, 1'b0, '0);
        add_row(arp_cmd(arprr_pkg::CMD_TICK, '0), 1'b0, 1'b0, '0);
        add_row(arp_cmd(arprr_pkg::CMD_RESOLVE, 32'h0A00_0001), 1'b0, 1'b0, '0);
        add_row(arp_pkt(HT_ETH, PT_IP4, HL_ETH, PL_IP4, OP_REQ, '0, '0, '0),
                1'b0, 1'b0, '0);
        add_row(arp_cmd(arprr_pkg::CMD_TICK, '0), 1'b0, 1'b0, '0);
        add_row(arp_pkt(HT_ETH, PT_IP4, HL_ETH, PL_IP4, OP_REP, '0, 32'h0A00_0001, '1),
                1'b0, 1'b0, '0);
        add_row(arp_cmd(arprr_pkg::CMD_RESOLVE, '0), 1'b0, 1'b0, '0);
        add_row(arp_pkt(HT_ETH, PT_IP4, HL_ETH, PL_IP4, OP_REP, 48'h0123_4567_89AB,
                        '0, '0), 1'b0, 1'b0, '0);

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int r = 0; r < dir_rows.size(); r++) begin
            drive_item(dir_rows[r].item, next_gap());
            got = arp_decide(dir_rows[r].item, b);
            if (dir_rows[r].typed) begin
                if (dir_rows[r].has_res)
                    arp_due_q.push_back(dir_rows[r].res);
            end else if (got) begin
                arp_due_q.push_back(b);
            end
            n_directed++;
        end

        for (p = 0; p < N_PHASES; p++) begin
            wait_drained();
            case (p)
                0: program_regs(32'($urandom), rand48(), 16'd1, 4'd0);
                1: program_regs('1, '1, 16'd3, 4'd15);
                // A timeout of zero expires on the first tick, like a timeout of one.
                2: program_regs('0, '0, 16'd0, 4'd2);
                3: program_regs(32'($urandom), rand48(), 16'hFFFF,
                                4'($urandom_range(0, 15)));
                4: program_regs(32'($urandom), rand48(), 16'($urandom_range(2, 6)),
                                4'($urandom_range(0, 15)));
                default: program_regs(32'($urandom), rand48(), 16'd5, 4'd3);
            endcase
            count = 0;
            while (count < PER_PHASE) begin
                x = gen_item(useful);
                drive_item(x, next_gap());
                if (arp_decide(x, b))
                    arp_due_q.push_back(b);
                n_random++;
                if (useful) begin
                    count++;
                    if (p == 1 && count == PER_PHASE / 2)
                        hold_req = 1'b1;
                    if (p == 4 && count == PER_PHASE / 2)
                        wait_drained();
                end
            end
        end

        wait_drained();
        repeat (20) @(posedge i_clk);
        $display("Run covered %0d directed and %0d random beats over %0d register settings.",
                 n_directed, n_random, N_PHASES + 1);
        $display("Results seen: %0d requests, %0d replies, %0d resolved, %0d timeouts, %0d busy.",
                 kind_seen[0], kind_seen[1], kind_seen[2], kind_seen[3], kind_seen[4]);
        if (n_err == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/arprr_pkg.sv
rtl/arprr_engine.sv
rtl/arp_resolver_responder.sv
sim/arp_resolver_responder_tb.sv
